FILE: rtl/free_block_bitmap_allocator_core_assert.svh
// Assertion macros for the free block bitmap allocator.
// Included by the RTL files that carry concurrent assertions; no dependencies.

`ifndef FREE_BLOCK_BITMAP_ALLOCATOR_CORE_ASSERT_SVH
`define FREE_BLOCK_BITMAP_ALLOCATOR_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Clocked check, switched off while reset is held
`define FBBA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("fbba assertion failed");

// Clocked check that also holds through reset
`define FBBA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("fbba assertion failed");

`else

`define FBBA_ASSERT(lbl, clk, rst_n, prop)
`define FBBA_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

FILE: rtl/fbba_pkg.sv
// Shared types and constants of the free block bitmap allocator.
// No dependencies; used by the channel interfaces and the core.

package fbba_pkg;

    // Size of the block map
    localparam int NUM_BLOCKS = 64;
    localparam int BLK_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

    // Fixed field widths of the item channels
    localparam int COUNT_W = 7;
    localparam int IDX_W   = 6;

    // Request mode codes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_ALLOCATED = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_FREED     = 2'd2,
        ST_INVALID   = 2'd3
    } t_status;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SINGLE,
        S_ALLOC
    } t_state;

endpackage

FILE: rtl/fbba_if.sv
// Valid/ready channel interfaces for requests and results of the allocator.
// Depends on fbba_pkg.

interface fbba_req_if import fbba_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               mode;
    logic [COUNT_W-1:0] block_count;
    logic [IDX_W-1:0]   free_index;

    modport source (output valid, mode, block_count, free_index, input ready);
    modport sink   (input valid, mode, block_count, free_index, output ready);
endinterface

interface fbba_res_if import fbba_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] block_index;
    t_status          status;
    logic             last;

    modport source (output valid, block_index, status, last, input ready);
    modport sink   (input valid, block_index, status, last, output ready);
endinterface

FILE: rtl/free_block_bitmap_allocator_core.sv
// Free block bitmap allocator: block map, free counter, sequencer and result register.
// Depends on fbba_pkg, fbba_if.sv and free_block_bitmap_allocator_core_assert.svh.

`include "free_block_bitmap_allocator_core_assert.svh"

// One request item is taken at a time. The request is classified in the cycle
// it is accepted; an allocate of n blocks then yields n result items, one per
// cycle while the result channel is not stalled, each found by a single
// priority encoder that picks the lowest free block of the map. A free, a
// no_space or an invalid request gives one result item. A stall of the
// result channel holds the sequencer. Results pass through an output
// register, so the last result of a request may still be waiting while the
// next request is taken. All blocks are free after reset; no clearing pass
// is needed.
module free_block_bitmap_allocator_core import fbba_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fbba_req_if.sink    i_req,
    fbba_res_if.source  o_res
);

    // Block map and bookkeeping
    logic [NUM_BLOCKS-1:0] r_used,        n_used;
    logic [COUNT_W-1:0]    r_free_total,  n_free_total;
    logic [COUNT_W-1:0]    r_remaining,   n_remaining;
    t_state                r_state,       n_state;

    // Pending single result
    t_status               r_pend_status, n_pend_status;
    logic [IDX_W-1:0]      r_pend_index,  n_pend_index;

    // Output register
    logic                  r_out_valid,   n_out_valid;
    logic [IDX_W-1:0]      r_out_index,   n_out_index;
    t_status               r_out_status,  n_out_status;
    logic                  r_out_last,    n_out_last;

    logic                  req_fire;
    logic                  slot_free;
    logic                  alloc_fire;
    logic [BLK_W-1:0]      scan_idx;
    logic [BLK_W-1:0]      req_blk;

    // Priority encoder: lowest free block
    always_comb begin
        scan_idx = '0;
        for (int b = NUM_BLOCKS - 1; b >= 0; b--) begin
            if (!r_used[b]) begin
                scan_idx = BLK_W'(b);
            end
        end
    end

    assign req_blk     = i_req.free_index[BLK_W-1:0];
    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;
    assign slot_free   = !r_out_valid || o_res.ready;
    assign alloc_fire  = (r_state == S_ALLOC) && slot_free;

    assign o_res.valid       = r_out_valid;
    assign o_res.block_index = r_out_index;
    assign o_res.status      = r_out_status;
    assign o_res.last        = r_out_last;

    // Sequencer: next state and datapath updates
    always_comb begin
        n_state       = r_state;
        n_used        = r_used;
        n_free_total  = r_free_total;
        n_remaining   = r_remaining;
        n_pend_status = r_pend_status;
        n_pend_index  = r_pend_index;
        n_out_valid   = r_out_valid;
        n_out_index   = r_out_index;
        n_out_status  = r_out_status;
        n_out_last    = r_out_last;

        // result taken downstream
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_pend_index = '0;
                    if (i_req.mode == MODE_ALLOC) begin
                        if (i_req.block_count == '0 ||
                            i_req.block_count > COUNT_W'(NUM_BLOCKS)) begin
                            n_pend_status = ST_INVALID;
                            n_state       = S_SINGLE;
                        end else if (i_req.block_count > r_free_total) begin
                            n_pend_status = ST_NO_SPACE;
                            n_state       = S_SINGLE;
                        end else begin
                            n_remaining = i_req.block_count;
                            n_state     = S_ALLOC;
                        end
                    end else begin
                        if ({1'b0, i_req.free_index} >= (IDX_W+1)'(NUM_BLOCKS) ||
                            !r_used[req_blk]) begin
                            n_pend_status = ST_INVALID;
                        end else begin
                            n_pend_status = ST_FREED;
                            n_pend_index  = i_req.free_index;
                        end
                        n_state = S_SINGLE;
                    end
                end
            end
            S_SINGLE: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_index  = r_pend_index;
                    n_out_status = r_pend_status;
                    n_out_last   = 1'b1;
                    if (r_pend_status == ST_FREED) begin
                        n_used[r_pend_index[BLK_W-1:0]] = 1'b0;
                        n_free_total = r_free_total + COUNT_W'(1);
                    end
                    n_state = S_IDLE;
                end
            end
            S_ALLOC: begin
                if (slot_free) begin
                    n_used[scan_idx] = 1'b1;
                    n_free_total     = r_free_total - COUNT_W'(1);
                    n_remaining      = r_remaining - COUNT_W'(1);
                    n_out_valid      = 1'b1;
                    n_out_index      = IDX_W'(scan_idx);
                    n_out_status     = ST_ALLOCATED;
                    n_out_last       = (r_remaining == COUNT_W'(1));
                    if (r_remaining == COUNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_used       <= '0;
            r_free_total <= COUNT_W'(NUM_BLOCKS);
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_used       <= n_used;
            r_free_total <= n_free_total;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_remaining   <= n_remaining;
        r_pend_status <= n_pend_status;
        r_pend_index  <= n_pend_index;
        r_out_index   <= n_out_index;
        r_out_status  <= n_out_status;
        r_out_last    <= n_out_last;
    end

    // Free counter tracks the map
    `FBBA_ASSERT(a_free_count, i_clk, i_rst_n, r_free_total == COUNT_W'(NUM_BLOCKS - $countones(r_used)))
    // An allocation in progress always has blocks left to hand out
    `FBBA_ASSERT(a_alloc_left, i_clk, i_rst_n, (r_state == S_ALLOC) |-> (r_remaining != '0 && !(&r_used)))
    // A handed-out block is marked used in the map
    `FBBA_ASSERT(a_alloc_marks, i_clk, i_rst_n, alloc_fire |=> r_used[r_out_index[BLK_W-1:0]])
    // No request is taken while a request is in progress
    `FBBA_ASSERT(a_one_at_a_time, i_clk, i_rst_n, req_fire |=> !i_req.ready)

endmodule
